FILE: rtl/tccw_pkg.sv
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared widths, cell constants and control character codes for the text
// console character writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tccw_pkg;

  localparam int CHAR_W    = 8;
  localparam int ROW_OUT_W = 5;
  localparam int COL_OUT_W = 7;
  localparam int CELL_W    = 16;

  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;
  localparam logic [7:0]        TEXT_ATTR  = 8'h07;

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;

endpackage

`default_nettype wire

FILE: rtl/tccw_if.sv
// ----------------------------------------------------------------------------
// tccw_char_if / tccw_cursor_if
// Valid/ready channels: character requests in, cursor reports out.
// ----------------------------------------------------------------------------
`default_nettype none

interface tccw_char_if;
  import tccw_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface tccw_cursor_if;
  import tccw_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ROW_OUT_W-1:0] cursor_row;
  logic [COL_OUT_W-1:0] cursor_col;
  logic                 scrolled;
  logic                 cell_written;

  modport source (output valid, output cursor_row, output cursor_col,
                  output scrolled, output cell_written, input ready);
  modport sink   (input valid, input cursor_row, input cursor_col,
                  input scrolled, input cell_written, output ready);
endinterface

`default_nettype wire

FILE: rtl/text_console_char_writer.sv
// ----------------------------------------------------------------------------
// text_console_char_writer
// Text console putchar: keeps a COLUMNS x TEXT_ROWS screen of cells in a RAM
// and a cursor, and reports the cursor after every character request.
//
// char_ch   : one character byte per request (valid/ready).
// cursor_ch : one report per request: cursor row/column, scrolled flag and
//             whether a printable character was stored.
// Reset clears the cursor and sweeps the screen RAM to 0x0720, one cell per
// cycle, through all COLUMNS*TEXT_ROWS cells; char_ch is not ready during the sweep.
// A request that does not scroll is handled in its accept cycle and its
// report is valid on the next cycle, so one request per cycle is sustained
// while cursor_ch is taken. A request that scrolls copies the screen up one
// row through the single RAM read port (read one cell, write it back one
// row higher, pipelined), then blanks the bottom row, and only then is its
// report valid.
// A new request is taken while the report register is empty or being taken;
// a stalled cursor_ch holds the report and blocks further requests.
// Assumes COLUMNS is a multiple of TAB_WIDTH.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_char_writer #(
  parameter int COLUMNS   = 80,
  parameter int TEXT_ROWS = 25,
  parameter int TAB_WIDTH = 8
) (
  input  wire logic   clk,
  input  wire logic   rst,
  tccw_char_if.sink   char_ch,
  tccw_cursor_if.source cursor_ch
);

  import tccw_pkg::*;

  localparam int CELLS  = COLUMNS * TEXT_ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int POS_W  = $clog2(CELLS + 1);
  localparam int COL_W  = $clog2(COLUMNS + 1);
  localparam int ROW_W  = $clog2(TEXT_ROWS + 1);
  localparam int PH_W   = $clog2(TAB_WIDTH);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_COPY,
    ST_DRAIN,
    ST_FILL
  } state_t;

  state_t             state;
  logic [ROW_W-1:0]   row;
  logic [COL_W-1:0]   col;
  logic [PH_W-1:0]    phase;
  logic [POS_W-1:0]   pos;
  logic [ADDR_W-1:0]  sweep;
  logic [ADDR_W-1:0]  dst;
  logic               pend;
  logic               out_valid;
  logic               scr;
  logic               wrote;

  logic               accept;
  logic               take;
  logic [ROW_W-1:0]   row_next;
  logic [COL_W-1:0]   col_next;
  logic [PH_W-1:0]    phase_next;
  logic [POS_W-1:0]   pos_next;
  logic               printable;
  logic               scroll_next;
  logic [COL_W-1:0]   step;
  logic [COL_W-1:0]   col_sum;

  logic               we;
  logic [ADDR_W-1:0]  waddr;
  logic [CELL_W-1:0]  wdata;
  logic [CELL_W-1:0]  rdata;

  tccw_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELLS)
  ) u_screen (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(sweep),
    .rdata(rdata)
  );

  assign take          = out_valid && cursor_ch.ready;
  assign char_ch.ready = (state == ST_IDLE) && (!out_valid || cursor_ch.ready);
  assign accept        = char_ch.valid && char_ch.ready;

  // cursor update for one character
  always_comb begin
    row_next   = row;
    col_next   = col;
    phase_next = phase;
    pos_next   = pos;
    printable  = 1'b0;
    step       = COL_W'(TAB_WIDTH) - COL_W'(phase);
    col_sum    = col + step;
    case (char_ch.char_code)
      CH_NEWLINE: begin
        col_next   = '0;
        row_next   = row + 1'b1;
        phase_next = '0;
        pos_next   = pos + POS_W'(COLUMNS) - POS_W'(col);
      end
      CH_TAB: begin
        phase_next = '0;
        pos_next   = pos + POS_W'(step);
        if (col_sum == COL_W'(COLUMNS)) begin
          col_next = '0;
          row_next = row + 1'b1;
        end else begin
          col_next = col_sum;
        end
      end
      CH_BACKSPACE: begin
        if (col != '0) begin
          col_next   = col - 1'b1;
          pos_next   = pos - 1'b1;
          phase_next = (phase == '0) ? PH_W'(TAB_WIDTH - 1) : phase - 1'b1;
        end
      end
      default: begin
        printable  = 1'b1;
        pos_next   = pos + 1'b1;
        phase_next = (phase == PH_W'(TAB_WIDTH - 1)) ? '0 : phase + 1'b1;
        if (col == COL_W'(COLUMNS - 1)) begin
          col_next = '0;
          row_next = row + 1'b1;
        end else begin
          col_next = col + 1'b1;
        end
      end
    endcase
    scroll_next = (row_next == ROW_W'(TEXT_ROWS));
  end

  // RAM write port: copy write-back, fill, clear, then character store
  always_comb begin
    we    = 1'b0;
    waddr = ADDR_W'(pos);
    wdata = {TEXT_ATTR, char_ch.char_code};
    if (pend) begin
      we    = 1'b1;
      waddr = dst;
      wdata = rdata;
    end else if (state == ST_FILL || state == ST_CLEAR) begin
      we    = 1'b1;
      waddr = sweep;
      wdata = BLANK_CELL;
    end else if (accept && printable) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      row       <= '0;
      col       <= '0;
      phase     <= '0;
      pos       <= '0;
      sweep     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
      scr       <= 1'b0;
      wrote     <= 1'b0;
    end else begin
      if (take) begin
        out_valid <= 1'b0;
      end
      pend <= 1'b0;
      case (state)
        ST_CLEAR: begin
          sweep <= sweep + 1'b1;
          if (sweep == ADDR_W'(CELLS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            col   <= col_next;
            phase <= phase_next;
            scr   <= scroll_next;
            wrote <= printable;
            if (scroll_next) begin
              row   <= row_next - 1'b1;
              pos   <= pos_next - POS_W'(COLUMNS);
              sweep <= ADDR_W'(COLUMNS);
              state <= ST_COPY;
            end else begin
              row       <= row_next;
              pos       <= pos_next;
              out_valid <= 1'b1;
            end
          end
        end
        ST_COPY: begin
          pend  <= 1'b1;
          dst   <= sweep - ADDR_W'(COLUMNS);
          if (sweep == ADDR_W'(CELLS - 1)) begin
            sweep <= ADDR_W'(CELLS - COLUMNS);
            state <= ST_DRAIN;
          end else begin
            sweep <= sweep + 1'b1;
          end
        end
        ST_DRAIN: begin
          state <= ST_FILL;
        end
        ST_FILL: begin
          if (sweep == ADDR_W'(CELLS - 1)) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end else begin
            sweep <= sweep + 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign cursor_ch.valid        = out_valid;
  assign cursor_ch.cursor_row   = ROW_OUT_W'(row);
  assign cursor_ch.cursor_col   = COL_OUT_W'(col);
  assign cursor_ch.scrolled     = scr;
  assign cursor_ch.cell_written = wrote;

  a_pos_matches_row_col: assert property (@(posedge clk) disable iff (rst)
    32'(pos) == 32'(row) * COLUMNS + 32'(col))
    else $error("linear cursor out of step with row/column");

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    col < COL_W'(COLUMNS))
    else $error("cursor column past last column");

  a_scroll_lands_bottom: assert property (@(posedge clk) disable iff (rst)
    out_valid && scr |-> row == ROW_W'(TEXT_ROWS - 1))
    else $error("scroll report not on bottom row");

  a_scroll_defers_report: assert property (@(posedge clk) disable iff (rst)
    accept && scroll_next |=> !out_valid && state == ST_COPY)
    else $error("scrolling request reported before copy");

endmodule

`default_nettype wire

FILE: rtl/tccw_ram.sv
// ----------------------------------------------------------------------------
// tccw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tccw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for text_console_char_writer: feeds character requests
// (control codes, printable bytes, long lines that wrap and scroll) and checks
// each cursor report against a cursor tracker kept in step with accepted
// requests.
// ----------------------------------------------------------------------------
module tb;
  import tccw_pkg::*;

  localparam int COLUMNS     = 80;
  localparam int TEXT_ROWS   = 25;
  localparam int TAB_WIDTH   = 8;
  localparam int CELL_COUNT  = COLUMNS * TEXT_ROWS;
  localparam int RANDOM_CHARS = 600;
  localparam int STALL_LIMIT = 40000;

  typedef struct packed {
    logic [ROW_OUT_W-1:0] row;
    logic [COL_OUT_W-1:0] col;
    logic                 scrolled;
    logic                 cell_written;
  } cursor_report_t;

  logic clk;
  logic rst;

  tccw_char_if   char_ch ();
  tccw_cursor_if cursor_ch ();

  text_console_char_writer #(
    .COLUMNS  (COLUMNS),
    .TEXT_ROWS(TEXT_ROWS),
    .TAB_WIDTH(TAB_WIDTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .char_ch  (char_ch),
    .cursor_ch(cursor_ch)
  );

  logic [CHAR_W-1:0] char_backlog[$];
  cursor_report_t    report_fifo[$];
  int unsigned       cursor_lin;
  int                total_chars;
  int                accepted_count;
  int                mismatch_count;
  int                stall_cycles;
  int                send_idle_pct;
  int                take_idle_pct;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Linear cursor tracker; returns the report the block owes for one request.
  function automatic cursor_report_t advance_cursor(logic [CHAR_W-1:0] ch);
    cursor_report_t r;
    r = '0;
    if (cursor_lin >= CELL_COUNT) cursor_lin = 0;
    case (ch)
      CH_NEWLINE:   cursor_lin = cursor_lin + COLUMNS - cursor_lin % COLUMNS;
      CH_TAB:       cursor_lin = cursor_lin + TAB_WIDTH - cursor_lin % TAB_WIDTH;
      CH_BACKSPACE: if (cursor_lin % COLUMNS != 0) cursor_lin = cursor_lin - 1;
      default: begin
        cursor_lin     = cursor_lin + 1;
        r.cell_written = 1'b1;
      end
    endcase
    while (cursor_lin >= CELL_COUNT) begin
      cursor_lin = cursor_lin - COLUMNS;
      r.scrolled = 1'b1;
    end
    r.row = ROW_OUT_W'(cursor_lin / COLUMNS);
    r.col = COL_OUT_W'(cursor_lin % COLUMNS);
    return r;
  endfunction

  function automatic logic [CHAR_W-1:0] printable_byte();
    logic [CHAR_W-1:0] c;
    c = CHAR_W'($urandom_range(0, 255));
    if (c == CH_NEWLINE || c == CH_TAB || c == CH_BACKSPACE) c = c ^ 8'h40;
    return c;
  endfunction

  task automatic queue_char(logic [CHAR_W-1:0] c);
    char_backlog.push_back(c);
  endtask

  // Idle mix by progress: sender-light/receiver-heavy, swapped, then none.
  always_comb begin
    if (accepted_count < total_chars / 3) begin
      send_idle_pct = 31;
      take_idle_pct = 61;
    end else if (accepted_count < 2 * total_chars / 3) begin
      send_idle_pct = 61;
      take_idle_pct = 31;
    end else begin
      send_idle_pct = 0;
      take_idle_pct = 0;
    end
  end

  // Request driver
  always @(posedge clk) begin
    if (rst) begin
      char_ch.valid <= 1'b0;
    end else begin
      if (char_ch.valid && char_ch.ready) begin
        report_fifo.push_back(advance_cursor(char_ch.char_code));
        accepted_count <= accepted_count + 1;
      end
      if (!char_ch.valid || char_ch.ready) begin
        if (char_backlog.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          char_ch.valid     <= 1'b1;
          char_ch.char_code <= char_backlog.pop_front();
        end else begin
          char_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Report monitor
  always @(posedge clk) begin : report_check
    cursor_report_t want;
    if (rst) begin
      cursor_ch.ready <= 1'b0;
    end else begin
      if (cursor_ch.valid && cursor_ch.ready) begin
        if (report_fifo.size() == 0) begin
          $error("cursor report with no request pending: row %0d col %0d",
                 cursor_ch.cursor_row, cursor_ch.cursor_col);
          mismatch_count++;
        end else begin
          want = report_fifo.pop_front();
          if (cursor_ch.cursor_row !== want.row) begin
            $error("cursor_row: expected %0d, got %0d", want.row, cursor_ch.cursor_row);
            mismatch_count++;
          end
          if (cursor_ch.cursor_col !== want.col) begin
            $error("cursor_col: expected %0d, got %0d", want.col, cursor_ch.cursor_col);
            mismatch_count++;
          end
          if (cursor_ch.scrolled !== want.scrolled) begin
            $error("scrolled: expected %0d, got %0d", want.scrolled, cursor_ch.scrolled);
            mismatch_count++;
          end
          if (cursor_ch.cell_written !== want.cell_written) begin
            $error("cell_written: expected %0d, got %0d",
                   want.cell_written, cursor_ch.cell_written);
            mismatch_count++;
          end
        end
      end
      cursor_ch.ready <= ($urandom_range(0, 99) >= take_idle_pct);
    end
  end

  // Watchdog: a scroll holds off everything while the screen is copied.
  always @(posedge clk) begin
    if (rst || (char_ch.valid && char_ch.ready) || (cursor_ch.valid && cursor_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("text_console_char_writer regression: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    int kind;
    int len;
    int r;
    rst               = 1'b1;
    char_ch.valid     = 1'b0;
    char_ch.char_code = '0;
    cursor_ch.ready   = 1'b0;
    cursor_lin        = 0;
    accepted_count    = 0;
    mismatch_count    = 0;
    stall_cycles      = 0;
    total_chars       = 0;

    // directed: backspace at column zero, byte extremes, tabs across a row
    queue_char(CH_BACKSPACE);
    queue_char(8'h00);
    queue_char(8'hFF);
    queue_char(8'h41);
    queue_char(CH_BACKSPACE);
    queue_char(CH_TAB);
    queue_char(CH_TAB);
    queue_char(CH_NEWLINE);
    queue_char(CH_NEWLINE);
    queue_char(CH_BACKSPACE);
    for (int i = 0; i < COLUMNS / TAB_WIDTH; i++) queue_char(CH_TAB);
    queue_char(8'h7F);
    queue_char(8'h80);
    queue_char(CH_BACKSPACE);
    queue_char(CH_BACKSPACE);

    // run the cursor off the bottom so later traffic scrolls
    for (int i = 0; i < TEXT_ROWS; i++) queue_char(CH_NEWLINE);

    // random: lines of text, long wrapping runs, control bursts, raw noise
    while (char_backlog.size() < RANDOM_CHARS) begin
      kind = $urandom_range(0, 9);
      if (kind <= 4) begin
        len = $urandom_range(1, 60);
        for (int i = 0; i < len; i++) begin
          r = $urandom_range(0, 99);
          if (r < 5) queue_char(CH_TAB);
          else if (r < 10) queue_char(CH_BACKSPACE);
          else queue_char(printable_byte());
        end
        queue_char(CH_NEWLINE);
      end else if (kind <= 6) begin
        len = $urandom_range(COLUMNS, 2 * COLUMNS + 10);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 99) < 12) queue_char(CH_TAB);
          else queue_char(printable_byte());
        end
      end else if (kind == 7) begin
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++) queue_char(CH_BACKSPACE);
      end else if (kind == 8) begin
        len = $urandom_range(1, 5);
        for (int i = 0; i < len; i++) queue_char(CH_NEWLINE);
      end else begin
        len = $urandom_range(1, 10);
        for (int i = 0; i < len; i++) queue_char(CHAR_W'($urandom_range(0, 255)));
      end
    end
    total_chars = char_backlog.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (accepted_count < total_chars || report_fifo.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("text_console_char_writer regression: pass");
    end else begin
      $display("text_console_char_writer regression: fail");
    end
    $finish;
  end

endmodule
